// ----- rtl/core/plist_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plist_pkg
// Shared codes and types for the positional list engine: item kinds, result
// status codes and the per-cycle command broadcast to the cell row.
// ----------------------------------------------------------------------------
package plist_pkg;

	// Field widths fixed by the interface
	localparam int ID_W    = 31;
	localparam int POS_W   = 8;
	localparam int KIND_W  = 3;
	localparam int STAT_W  = 2;
	localparam int SIZE_W  = 7;
	localparam int RIDX_W  = 6;
	// Cell index width; covers the largest supported row of 64 cells
	localparam int CIDX_W  = 6;

	// Item kinds
	localparam logic [KIND_W-1:0] KIND_INS_FRONT = 3'd0;
	localparam logic [KIND_W-1:0] KIND_INS_BACK  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_INS_AT    = 3'd2;
	localparam logic [KIND_W-1:0] KIND_REM_FRONT = 3'd3;
	localparam logic [KIND_W-1:0] KIND_REM_BACK  = 3'd4;
	localparam logic [KIND_W-1:0] KIND_REM_AT    = 3'd5;
	localparam logic [KIND_W-1:0] KIND_DUMP      = 3'd6;

	// Result status codes
	localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
	localparam logic [STAT_W-1:0] ST_BADPOS = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd2;
	localparam logic [STAT_W-1:0] ST_FULL   = 2'd3;

	// Cell row commands
	localparam logic [1:0] OP_HOLD = 2'd0;
	localparam logic [1:0] OP_INS  = 2'd1;
	localparam logic [1:0] OP_REM  = 2'd2;
	localparam logic [1:0] OP_ROT  = 2'd3;

	// Command broadcast to every cell: insert/remove position, or the tail
	// index for a rotate
	typedef struct packed {
		logic [1:0]        op;
		logic [CIDX_W-1:0] pos;
	} plist_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/core/plist_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plist_cell
// One slot of the list row. Holds one identifier and takes its left or right
// neighbor, the new identifier or the head value as the broadcast command says.
// ----------------------------------------------------------------------------
module plist_cell #(
	parameter int IDX = 0
) (
	input  wire                           clk,
	input  plist_pkg::plist_ctl_t         ctl,
	input  wire  [plist_pkg::ID_W-1:0]    new_id,
	input  wire  [plist_pkg::ID_W-1:0]    left,
	input  wire  [plist_pkg::ID_W-1:0]    right,
	input  wire  [plist_pkg::ID_W-1:0]    head,
	output logic [plist_pkg::ID_W-1:0]    data
);

	localparam logic [plist_pkg::CIDX_W-1:0] MY_IDX = plist_pkg::CIDX_W'(IDX);

	logic [plist_pkg::ID_W-1:0] data_q;
	logic [plist_pkg::ID_W-1:0] data_d;

	// Pick the next content of this slot
	always_comb begin
		data_d = data_q;
		case (ctl.op)
			plist_pkg::OP_INS: begin
				if (MY_IDX == ctl.pos) data_d = new_id;
				else if (MY_IDX > ctl.pos) data_d = left;
			end
			plist_pkg::OP_REM: begin
				if (MY_IDX >= ctl.pos) data_d = right;
			end
			plist_pkg::OP_ROT: begin
				if (MY_IDX == ctl.pos) data_d = head;
				else if (MY_IDX < ctl.pos) data_d = right;
			end
			default: data_d = data_q;
		endcase
	end

	// Hold the slot
	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data = data_q;

endmodule
`default_nettype wire

// ----- rtl/core/positional_list_engine_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// positional_list_engine_unit
// Bounded ordered list of identifiers held in a row of cells. Inserts and
// removes at front, back or an index; a dump streams every entry in order.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-----------------------------------
//  in      | input     | in_valid / in_ready   | kind, position, entry_id
//  out     | output    | out_valid / out_ready | result_id, result_index, status,
//          |           |                       | size_after, last
//
//  A successful insert or remove shifts every entry at or beyond the position
//  one cell as the item is taken; each item but a dump gives one transfer.
//  A dump of N entries gives N transfers: while the output is free the row
//  rotates one cell per cycle, emitting cell 0; no item is taken till it ends.
//  After reset the list is empty; the slots need no clearing.
//  A stalled output holds the result register and blocks new items.
// ----------------------------------------------------------------------------
module positional_list_engine_unit #(
	parameter int DEPTH = 64
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                in_valid,
	output logic                               in_ready,
	input  wire  [plist_pkg::KIND_W-1:0]       kind,
	input  wire  [plist_pkg::POS_W-1:0]        position,
	input  wire  [plist_pkg::ID_W-1:0]         entry_id,
	output logic                               out_valid,
	input  wire                                out_ready,
	output logic [plist_pkg::ID_W-1:0]         result_id,
	output logic [plist_pkg::RIDX_W-1:0]       result_index,
	output logic [plist_pkg::STAT_W-1:0]       status,
	output logic [plist_pkg::SIZE_W-1:0]       size_after,
	output logic                               last
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = $clog2(DEPTH);

	// Control state
	logic [CW-1:0] count_q;
	logic          dump_q;
	logic [IW-1:0] dump_idx_q;
	logic          out_valid_q;

	// Result register
	logic [plist_pkg::ID_W-1:0]   rid_q;
	logic [plist_pkg::RIDX_W-1:0] ridx_q;
	logic [plist_pkg::STAT_W-1:0] stat_q;
	logic [plist_pkg::SIZE_W-1:0] size_q;
	logic                         last_q;

	// Cell row
	logic [plist_pkg::ID_W-1:0] cell_data [DEPTH];
	plist_pkg::plist_ctl_t      ctl;

	// Next-state signals
	logic                         out_free;
	logic                         accept;
	logic                         dump_step;
	logic                         load;
	logic [CW-1:0]                count_d;
	logic                         dump_d;
	logic [IW-1:0]                dump_idx_d;
	logic [plist_pkg::ID_W-1:0]   rid_d;
	logic [plist_pkg::RIDX_W-1:0] ridx_d;
	logic [plist_pkg::STAT_W-1:0] stat_d;
	logic                         last_d;
	logic [plist_pkg::POS_W-1:0]  cnt8;
	logic [plist_pkg::POS_W-1:0]  ipos;
	logic [plist_pkg::POS_W-1:0]  rpos;
	logic [plist_pkg::ID_W-1:0]   tap_id;
	logic                         is_ins;
	logic                         is_rem;
	logic                         dump_last;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = !dump_q && out_free;
	assign accept    = in_valid && in_ready;
	assign dump_step = dump_q && out_free;
	assign load      = accept || dump_step;
	assign cnt8      = plist_pkg::POS_W'(count_q);
	assign dump_last = (CW'(dump_idx_q) == count_q - 1'b1);

	// Pick insert and remove positions
	always_comb begin
		is_ins = 1'b0;
		is_rem = 1'b0;
		ipos   = '0;
		rpos   = '0;
		case (kind)
			plist_pkg::KIND_INS_FRONT: begin is_ins = 1'b1; ipos = '0; end
			plist_pkg::KIND_INS_BACK:  begin is_ins = 1'b1; ipos = cnt8; end
			plist_pkg::KIND_INS_AT:    begin is_ins = 1'b1; ipos = position; end
			plist_pkg::KIND_REM_FRONT: begin is_rem = 1'b1; rpos = '0; end
			plist_pkg::KIND_REM_BACK:  begin is_rem = 1'b1; rpos = cnt8 - 1'b1; end
			plist_pkg::KIND_REM_AT:    begin is_rem = 1'b1; rpos = position; end
			default: begin is_ins = 1'b0; is_rem = 1'b0; end
		endcase
	end

	// Select the identifier at the remove position
	always_comb begin
		tap_id = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (rpos == plist_pkg::POS_W'(i)) tap_id = tap_id | cell_data[i];
		end
	end

	// Decide the command, the new count and the result
	always_comb begin
		ctl.op     = plist_pkg::OP_HOLD;
		ctl.pos    = '0;
		count_d    = count_q;
		dump_d     = dump_q;
		dump_idx_d = dump_idx_q;
		rid_d      = '0;
		ridx_d     = '0;
		stat_d     = plist_pkg::ST_OK;
		last_d     = 1'b1;
		if (dump_step) begin
			ctl.op     = plist_pkg::OP_ROT;
			ctl.pos    = plist_pkg::CIDX_W'(count_q - 1'b1);
			rid_d      = cell_data[0];
			ridx_d     = plist_pkg::RIDX_W'(dump_idx_q);
			last_d     = dump_last;
			dump_idx_d = dump_idx_q + 1'b1;
			dump_d     = !dump_last;
		end else if (accept) begin
			if (is_ins) begin
				if (ipos > cnt8) stat_d = plist_pkg::ST_BADPOS;
				else if (count_q == CW'(DEPTH)) stat_d = plist_pkg::ST_FULL;
				else begin
					ctl.op  = plist_pkg::OP_INS;
					ctl.pos = plist_pkg::CIDX_W'(ipos);
					count_d = count_q + 1'b1;
				end
			end else if (is_rem) begin
				if (count_q == '0) stat_d = plist_pkg::ST_EMPTY;
				else if (rpos >= cnt8) stat_d = plist_pkg::ST_BADPOS;
				else begin
					ctl.op  = plist_pkg::OP_REM;
					ctl.pos = plist_pkg::CIDX_W'(rpos);
					rid_d   = tap_id;
					count_d = count_q - 1'b1;
				end
			end else if (kind == plist_pkg::KIND_DUMP) begin
				if (count_q == '0) stat_d = plist_pkg::ST_EMPTY;
				else begin
					// Emit the head now, rotate, stream the rest
					ctl.op     = plist_pkg::OP_ROT;
					ctl.pos    = plist_pkg::CIDX_W'(count_q - 1'b1);
					rid_d      = cell_data[0];
					last_d     = (count_q == CW'(1));
					dump_d     = (count_q != CW'(1));
					dump_idx_d = IW'(1);
				end
			end
		end
	end

	// Build the row of cells
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic [plist_pkg::ID_W-1:0] left_id;
		logic [plist_pkg::ID_W-1:0] right_id;
		if (g == 0) begin : g_first
			assign left_id = '0;
		end else begin : g_mid_l
			assign left_id = cell_data[g-1];
		end
		if (g == DEPTH - 1) begin : g_end
			assign right_id = '0;
		end else begin : g_mid_r
			assign right_id = cell_data[g+1];
		end
		plist_cell #(
			.IDX(g)
		) u_cell (
			.clk    (clk),
			.ctl    (ctl),
			.new_id (entry_id),
			.left   (left_id),
			.right  (right_id),
			.head   (cell_data[0]),
			.data   (cell_data[g])
		);
	end

	// Advance control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			dump_q      <= 1'b0;
			dump_idx_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q    <= count_d;
			dump_q     <= dump_d;
			dump_idx_q <= dump_idx_d;
			if (load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// Load the result register
	always_ff @(posedge clk) begin
		if (load) begin
			rid_q  <= rid_d;
			ridx_q <= ridx_d;
			stat_q <= stat_d;
			size_q <= plist_pkg::SIZE_W'(count_d);
			last_q <= last_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_id    = rid_q;
	assign result_index = ridx_q;
	assign status       = stat_q;
	assign size_after   = size_q;
	assign last         = last_q;

endmodule
`default_nettype wire

// ----- bench/positional_list_engine_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_engine_unit_tb
// Self-checking bench for the positional list engine. A directed sequence
// covers empty, bad-position and unused-kind cases, then random traffic fills
// the list to capacity and starts to drain it. A shadow list predicts every
// result, and a monitor compares each output transfer field by field.
// ----------------------------------------------------------------------------
module positional_list_engine_unit_tb;
	import plist_pkg::*;

	localparam int DEPTH        = 64;
	localparam int RANDOM_OPS   = 80;
	localparam int LONG_HOLD    = 100;
	localparam int HOLD_AFTER   = 40;
	localparam int IDLE_LIMIT   = 2000;

	// Kind code with no operation behind it
	localparam logic [KIND_W-1:0] KIND_SPARE = 3'd7;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [POS_W-1:0]  pos;
		logic [ID_W-1:0]   id;
	} list_op_t;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [RIDX_W-1:0] index;
		logic [STAT_W-1:0] status;
		logic [SIZE_W-1:0] size;
		logic              last;
	} list_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [KIND_W-1:0] kind = '0;
	logic [POS_W-1:0] position = '0;
	logic [ID_W-1:0] entry_id = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [ID_W-1:0] result_id;
	logic [RIDX_W-1:0] result_index;
	logic [STAT_W-1:0] status;
	logic [SIZE_W-1:0] size_after;
	logic last;

	positional_list_engine_unit #(
		.DEPTH(DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.position(position),
		.entry_id(entry_id),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result_id(result_id),
		.result_index(result_index),
		.status(status),
		.size_after(size_after),
		.last(last)
	);

	// Stimulus and prediction state
	list_op_t ops_to_send[$];
	list_result_t list_results_due[$];
	logic [ID_W-1:0] shadow_ids [DEPTH];
	int unsigned shadow_count = 0;
	int unsigned gen_count = 0;
	int total_ops = 0;
	int ops_taken = 0;
	int results_seen = 0;
	int mismatch_count = 0;
	int idle_cycles = 0;
	logic in_took = 1'b0;

	// Sender and receiver pacing
	list_op_t drive_op;
	int tx_gap = 0;
	int tx_calm = 0;
	int rx_stall = 0;
	int rx_calm = 0;
	logic hold_done = 1'b0;

	initial begin
		forever #10 clk = ~clk;
	end

	// Mostly short gaps, now and then a long one
	function automatic int pick_gap();
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Queue one operation and track the list size it leaves behind
	task automatic queue_op(input logic [KIND_W-1:0] k, input logic [POS_W-1:0] p,
			input logic [ID_W-1:0] id);
		list_op_t op;
		int unsigned at;
		op.kind = k;
		op.pos = p;
		op.id = id;
		ops_to_send.push_back(op);
		case (k)
			KIND_INS_FRONT, KIND_INS_BACK, KIND_INS_AT: begin
				at = (k == KIND_INS_FRONT) ? 0 : (k == KIND_INS_BACK) ? gen_count : p;
				if (at <= gen_count && gen_count < DEPTH)
					gen_count++;
			end
			KIND_REM_FRONT, KIND_REM_BACK, KIND_REM_AT: begin
				at = (k == KIND_REM_AT) ? p : 0;
				if (gen_count != 0 && at < gen_count)
					gen_count--;
			end
			default: ;
		endcase
	endtask

	// Apply one operation to the shadow list and queue the results it yields
	task automatic apply_list_op(input list_op_t op);
		list_result_t r;
		int unsigned at;
		r = '0;
		r.last = 1'b1;
		case (op.kind)
			KIND_INS_FRONT, KIND_INS_BACK, KIND_INS_AT: begin
				at = (op.kind == KIND_INS_FRONT) ? 0 :
					(op.kind == KIND_INS_BACK) ? shadow_count : op.pos;
				if (at > shadow_count) begin
					r.status = ST_BADPOS;
				end else if (shadow_count >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					for (int i = shadow_count; i > at; i--)
						shadow_ids[i] = shadow_ids[i-1];
					shadow_ids[at] = op.id;
					shadow_count++;
					r.status = ST_OK;
				end
			end
			KIND_REM_FRONT, KIND_REM_BACK, KIND_REM_AT: begin
				if (shadow_count == 0) begin
					r.status = ST_EMPTY;
				end else begin
					at = (op.kind == KIND_REM_FRONT) ? 0 :
						(op.kind == KIND_REM_BACK) ? shadow_count - 1 : op.pos;
					if (at >= shadow_count) begin
						r.status = ST_BADPOS;
					end else begin
						r.id = shadow_ids[at];
						for (int i = at; i + 1 < shadow_count; i++)
							shadow_ids[i] = shadow_ids[i+1];
						shadow_count--;
						r.status = ST_OK;
					end
				end
			end
			KIND_DUMP: begin
				if (shadow_count == 0) begin
					r.status = ST_EMPTY;
				end else begin
					// One result per entry, last marks the tail
					for (int i = 0; i < shadow_count; i++) begin
						r.id = shadow_ids[i];
						r.index = i[RIDX_W-1:0];
						r.status = ST_OK;
						r.size = shadow_count[SIZE_W-1:0];
						r.last = (i + 1 == shadow_count);
						list_results_due.push_back(r);
					end
					return;
				end
			end
			default: r.status = ST_OK;
		endcase
		r.size = shadow_count[SIZE_W-1:0];
		list_results_due.push_back(r);
	endtask

	task automatic check_field(input string field_name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h",
				$time, field_name, want, got);
			mismatch_count++;
		end
	endtask

	// Drive the input channel from the pending queue
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_took)) begin
			if (tx_gap > 0) begin
				in_valid <= 1'b0;
				tx_gap <= tx_gap - 1;
			end else if (ops_to_send.size() != 0) begin
				drive_op = ops_to_send.pop_front();
				kind <= drive_op.kind;
				position <= drive_op.pos;
				entry_id <= drive_op.id;
				in_valid <= 1'b1;
				if (tx_calm > 0) begin
					tx_calm <= tx_calm - 1;
					tx_gap <= 0;
				end else if ($urandom_range(0, 99) < 5) begin
					tx_calm <= $urandom_range(10, 30);
					tx_gap <= 0;
				end else if ($urandom_range(0, 1) == 0) begin
					tx_gap <= 0;
				end else begin
					tx_gap <= pick_gap();
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Pace the output side; one long hold backs the block up into its input
	always @(negedge clk) begin
		if (arst_n) begin
			if (!hold_done && results_seen >= HOLD_AFTER) begin
				hold_done <= 1'b1;
				out_ready <= 1'b0;
				rx_stall <= LONG_HOLD - 1;
			end else if (rx_stall > 0) begin
				out_ready <= 1'b0;
				rx_stall <= rx_stall - 1;
			end else if (rx_calm > 0) begin
				out_ready <= 1'b1;
				rx_calm <= rx_calm - 1;
			end else if ($urandom_range(0, 99) < 6) begin
				out_ready <= 1'b1;
				rx_calm <= $urandom_range(20, 60);
			end else if ($urandom_range(0, 99) < 25) begin
				out_ready <= 1'b0;
				rx_stall <= pick_gap() - 1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Predict on input transfers, check output transfers, watch for a hang
	always @(posedge clk) begin
		list_result_t want;
		list_op_t seen_op;
		in_took <= arst_n && in_valid && in_ready;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				seen_op.kind = kind;
				seen_op.pos = position;
				seen_op.id = entry_id;
				apply_list_op(seen_op);
				ops_taken++;
			end
			if (out_valid && out_ready) begin
				results_seen++;
				if (list_results_due.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual id %0h status %0d",
						$time, result_id, status);
					mismatch_count++;
				end else begin
					want = list_results_due.pop_front();
					check_field("result_id", want.id, result_id);
					check_field("result_index", want.index, result_index);
					check_field("status", want.status, status);
					check_field("size_after", want.size, size_after);
					check_field("last", want.last, last);
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// Build the stimulus, release reset, wait for the drain
	initial begin
		logic [KIND_W-1:0] pick_kind;
		logic [POS_W-1:0] pick_pos;
		logic filling;
		logic full_dumped;
		int full_tries;
		int roll;

		// Empty list, unused kind, bad positions, small list
		queue_op(KIND_REM_FRONT, 8'd0, 31'd0);
		queue_op(KIND_REM_BACK, 8'd255, 31'h7FFFFFFF);
		queue_op(KIND_REM_AT, 8'd0, 31'd0);
		queue_op(KIND_DUMP, 8'd0, 31'd0);
		queue_op(KIND_SPARE, 8'd255, 31'h7FFFFFFF);
		queue_op(KIND_INS_AT, 8'd1, 31'h1234);
		queue_op(KIND_INS_FRONT, 8'd0, 31'h7FFFFFFF);
		queue_op(KIND_INS_BACK, 8'd255, 31'd0);
		queue_op(KIND_INS_AT, 8'd1, 31'h2AAAAAAA);
		queue_op(KIND_INS_AT, 8'd3, 31'h55555555);
		queue_op(KIND_INS_AT, 8'd255, 31'h1);
		queue_op(KIND_DUMP, 8'd255, 31'h7FFFFFFF);
		queue_op(KIND_REM_AT, 8'd4, 31'd0);
		queue_op(KIND_REM_AT, 8'd255, 31'd0);
		queue_op(KIND_REM_AT, 8'd1, 31'd0);
		queue_op(KIND_REM_BACK, 8'd0, 31'd0);
		queue_op(KIND_REM_FRONT, 8'd0, 31'd0);
		queue_op(KIND_SPARE, 8'd0, 31'd0);
		queue_op(KIND_DUMP, 8'd0, 31'd0);
		queue_op(KIND_REM_AT, 8'd0, 31'd0);
		queue_op(KIND_DUMP, 8'd0, 31'd0);

		// Fill to capacity, dump a full list, hit the bound, then drain
		filling = 1'b1;
		full_dumped = 1'b0;
		full_tries = 0;
		for (int n = 0; n < RANDOM_OPS; n++) begin
			roll = $urandom_range(0, 99);
			pick_pos = POS_W'($urandom_range(0, 255));
			if (filling && gen_count == DEPTH && !full_dumped) begin
				full_dumped = 1'b1;
				pick_kind = KIND_DUMP;
			end else if (filling && gen_count == DEPTH) begin
				pick_kind = KIND_W'($urandom_range(KIND_INS_FRONT, KIND_INS_AT));
				pick_pos = POS_W'($urandom_range(0, gen_count));
				full_tries++;
				if (full_tries >= 3)
					filling = 1'b0;
			end else if (roll < 3) begin
				pick_kind = KIND_DUMP;
			end else if (!filling && roll < 12) begin
				// Noise: any kind, any position
				pick_kind = KIND_W'($urandom_range(0, 7));
			end else if (!filling && roll >= 20) begin
				pick_kind = KIND_W'($urandom_range(KIND_REM_FRONT, KIND_REM_AT));
				if (pick_kind == KIND_REM_AT && gen_count != 0)
					pick_pos = POS_W'($urandom_range(0, gen_count - 1));
			end else begin
				pick_kind = KIND_W'($urandom_range(KIND_INS_FRONT, KIND_INS_AT));
				if (pick_kind == KIND_INS_AT)
					pick_pos = POS_W'($urandom_range(0, gen_count));
			end
			queue_op(pick_kind, pick_pos, ID_W'($urandom()));
		end
		total_ops = ops_to_send.size();

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (ops_taken < total_ops)
			@(posedge clk);
		while (list_results_due.size() != 0)
			@(posedge clk);
		repeat (DEPTH + 8) @(posedge clk);

		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
